>>> hw/rtl/cef_pkg.sv
// ----------------------------------------------------------------------------
// cef_pkg
// shared types, widths and the edge table of the cube edge intersection block
// ----------------------------------------------------------------------------
package cef_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int HALF_BITS   = 24;
    localparam int NUM_EDGES   = 12;
    // |va| fits SAMPLE_BITS unsigned, the fraction needs one more bit
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int PROD_BITS   = HALF_BITS + QUO_BITS;
    localparam int OFF_BITS    = PROD_BITS - (FRAC_BITS - 1);
    localparam int WIDE_BITS   = COORD_BITS + 2;
    localparam int CNT_BITS    = $clog2(QUO_BITS + 1);

    typedef struct packed {
        logic [7:0][SAMPLE_BITS-1:0] corner;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic [HALF_BITS-1:0]         half;
        logic [7:0]                   idx;
        logic [NUM_EDGES-1:0]         cuts;
    } job_t;

    function automatic logic [2:0] edge_lo(input logic [3:0] e);
        logic [2:0] r;
        unique case (e)
            4'd0, 4'd1, 4'd2: r = 3'd0;
            4'd3, 4'd4:       r = 3'd1;
            4'd5, 4'd6:       r = 3'd2;
            4'd7:             r = 3'd3;
            4'd8, 4'd9:       r = 3'd4;
            4'd10:            r = 3'd5;
            4'd11:            r = 3'd6;
            default:          r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_hi(input logic [3:0] e);
        logic [2:0] r;
        unique case (e)
            4'd0:             r = 3'd1;
            4'd1:             r = 3'd2;
            4'd2:             r = 3'd4;
            4'd3, 4'd5:       r = 3'd3;
            4'd4, 4'd8:       r = 3'd5;
            4'd6, 4'd9:       r = 3'd6;
            4'd7, 4'd10, 4'd11: r = 3'd7;
            default:          r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cef_if.sv
// ----------------------------------------------------------------------------
// cef channel interfaces
// cube request channel and cut result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cef_cube_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] corner_0;
    logic signed [15:0] corner_1;
    logic signed [15:0] corner_2;
    logic signed [15:0] corner_3;
    logic signed [15:0] corner_4;
    logic signed [15:0] corner_5;
    logic signed [15:0] corner_6;
    logic signed [15:0] corner_7;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [23:0]        half_edge;

    modport source (output valid, corner_0, corner_1, corner_2, corner_3, corner_4,
        corner_5, corner_6, corner_7, center_x, center_y, center_z, half_edge,
        input ready);
    modport sink (input valid, corner_0, corner_1, corner_2, corner_3, corner_4,
        corner_5, corner_6, corner_7, center_x, center_y, center_z, half_edge,
        output ready);
endinterface

interface cef_cut_if;
    logic               valid;
    logic               ready;
    logic [7:0]         cube_index;
    logic               has_cut;
    logic [3:0]         edge_number;
    logic [2:0]         from_corner;
    logic [2:0]         to_corner;
    logic signed [31:0] cut_x;
    logic signed [31:0] cut_y;
    logic signed [31:0] cut_z;
    logic               last_of_cube;

    modport source (output valid, cube_index, has_cut, edge_number, from_corner,
        to_corner, cut_x, cut_y, cut_z, last_of_cube, input ready);
    modport sink (input valid, cube_index, has_cut, edge_number, from_corner,
        to_corner, cut_x, cut_y, cut_z, last_of_cube, output ready);
endinterface

>>> hw/rtl/cef_front.sv
// ----------------------------------------------------------------------------
// cef_front
// accepts a cube, forms the cube index and the mask of cut edges
// ----------------------------------------------------------------------------
module cef_front
    import cef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cef_cube_if.sink    cube,
    output logic        push_valid,
    input  logic        push_ready,
    output job_t        push_job
);

    logic                 vld_reg;
    job_t                 job_reg;
    job_t                 job_next;
    logic [7:0]           idx;
    logic [NUM_EDGES-1:0] cuts;
    logic [7:0][SAMPLE_BITS-1:0] smp;

    assign smp = {cube.corner_7, cube.corner_6, cube.corner_5, cube.corner_4,
                  cube.corner_3, cube.corner_2, cube.corner_1, cube.corner_0};

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            idx[k] = ($signed(smp[k]) > 0);
        end
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            cuts[e] = idx[edge_lo(4'(e))] ^ idx[edge_hi(4'(e))];
        end
        job_next.corner = smp;
        job_next.cx     = cube.center_x;
        job_next.cy     = cube.center_y;
        job_next.cz     = cube.center_z;
        job_next.half   = cube.half_edge;
        job_next.idx    = idx;
        job_next.cuts   = cuts;
    end

    assign cube.ready = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_job   = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (cube.ready)
        begin
            vld_reg <= cube.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cube.valid && cube.ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

>>> hw/rtl/cef_queue.sv
// ----------------------------------------------------------------------------
// cef_queue
// two-entry queue of classified cubes between front and back
// ----------------------------------------------------------------------------
module cef_queue
    import cef_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       mem [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = mem[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/cef_back.sv
// ----------------------------------------------------------------------------
// cef_back
// walks the cut edges of one cube: divide, scale, place and emit each cut
// ----------------------------------------------------------------------------
module cef_back
    import cef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  job_t     pop_job,
    cef_cut_if.source cut
);

    typedef enum logic [2:0] {S_IDLE, S_SEL, S_DIV, S_MUL, S_ADD, S_OUT} state_t;

    state_t                state_reg;
    job_t                  job_reg;
    logic [NUM_EDGES-1:0]  mask_reg;
    logic [3:0]            edge_reg;
    logic [2:0]            lo_reg;
    logic [2:0]            hi_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic [QUO_BITS-1:0]   num_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [PROD_BITS-1:0]  prod_reg;

    logic                  vld_reg;
    logic                  has_reg;
    logic                  last_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] z_reg;

    // edge selection and divider setup
    logic [3:0]              sel_e;
    logic [2:0]              sel_lo;
    logic [2:0]              sel_hi;
    logic signed [SAMPLE_BITS:0] va;
    logic signed [SAMPLE_BITS:0] vb;
    logic signed [SAMPLE_BITS:0] dif;
    logic [SAMPLE_BITS:0]    mag_a;
    logic [SAMPLE_BITS:0]    mag_d;
    logic [SAMPLE_BITS:0]    trial;
    logic                    qbit;

    // coordinate placement
    logic signed [WIDE_BITS-1:0] cw [3];
    logic signed [WIDE_BITS-1:0] hw;
    logic signed [WIDE_BITS-1:0] ow;
    logic signed [WIDE_BITS-1:0] vw [3];
    logic signed [COORD_BITS-1:0] sat [3];
    logic [2:0]                   axis_bit;

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    always_comb
    begin
        sel_e = 4'd0;
        for (int e = NUM_EDGES - 1; e >= 0; e--)
        begin
            if (mask_reg[e])
            begin
                sel_e = 4'(e);
            end
        end
        sel_lo = edge_lo(sel_e);
        sel_hi = edge_hi(sel_e);
        va     = (SAMPLE_BITS+1)'($signed(job_reg.corner[sel_lo]));
        vb     = (SAMPLE_BITS+1)'($signed(job_reg.corner[sel_hi]));
        dif    = va - vb;
        mag_a  = va[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-va) : va;
        mag_d  = dif[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dif) : dif;
        // restoring step, one quotient bit
        trial  = {rem_reg, num_reg[QUO_BITS-1]};
        qbit   = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        hw = WIDE_BITS'($signed({1'b0, job_reg.half}));
        ow = WIDE_BITS'($signed({1'b0, prod_reg[PROD_BITS-1:FRAC_BITS-1]}));
        cw[0] = WIDE_BITS'(job_reg.cx);
        cw[1] = WIDE_BITS'(job_reg.cy);
        cw[2] = WIDE_BITS'(job_reg.cz);
        for (int a = 0; a < 3; a++)
        begin
            axis_bit = 3'(3'b100 >> a);
            if ((lo_reg ^ hi_reg) == axis_bit)
            begin
                vw[a] = cw[a] - hw + ow;
            end
            else if ((lo_reg & axis_bit) != 3'd0)
            begin
                vw[a] = cw[a] + hw;
            end
            else
            begin
                vw[a] = cw[a] - hw;
            end
            if (vw[a] > WIDE_BITS'(CMAX))
            begin
                sat[a] = CMAX;
            end
            else if (vw[a] < WIDE_BITS'(CMIN))
            begin
                sat[a] = CMIN;
            end
            else
            begin
                sat[a] = vw[a][COORD_BITS-1:0];
            end
        end
    end

    assign pop_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        if (pop_job.cuts == '0)
                        begin
                            vld_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SEL;
                        end
                    end
                end
                S_SEL: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == CNT_BITS'(1))
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_ADD;
                S_ADD:
                begin
                    vld_reg   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (cut.ready)
                    begin
                        vld_reg   <= 1'b0;
                        state_reg <= last_reg ? S_IDLE : S_SEL;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg  <= pop_job;
                mask_reg <= pop_job.cuts;
                has_reg  <= 1'b0;
                last_reg <= 1'b1;
                edge_reg <= 4'd0;
                lo_reg   <= 3'd0;
                hi_reg   <= 3'd0;
                x_reg    <= '0;
                y_reg    <= '0;
                z_reg    <= '0;
            end
            S_SEL:
            begin
                edge_reg <= sel_e;
                lo_reg   <= sel_lo;
                hi_reg   <= sel_hi;
                mask_reg[sel_e] <= 1'b0;
                // numerator |va| << FRAC_BITS, top bits already below divisor
                rem_reg  <= {1'b0, mag_a[SAMPLE_BITS-1:1]};
                num_reg  <= {mag_a[0], {(QUO_BITS-1){1'b0}}};
                den_reg  <= mag_d[SAMPLE_BITS-1:0];
                cnt_reg  <= CNT_BITS'(QUO_BITS);
            end
            S_DIV:
            begin
                rem_reg <= qbit ? SAMPLE_BITS'(trial - {1'b0, den_reg})
                                : trial[SAMPLE_BITS-1:0];
                num_reg <= {num_reg[QUO_BITS-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_BITS-2:0], qbit};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
            S_MUL:
            begin
                prod_reg <= PROD_BITS'(job_reg.half) * PROD_BITS'(quo_reg);
            end
            S_ADD:
            begin
                has_reg  <= 1'b1;
                last_reg <= (mask_reg == '0);
                x_reg    <= sat[0];
                y_reg    <= sat[1];
                z_reg    <= sat[2];
            end
            S_OUT: ;
            default: ;
        endcase
    end

    assign cut.valid        = vld_reg;
    assign cut.cube_index   = job_reg.idx;
    assign cut.has_cut      = has_reg;
    assign cut.edge_number  = edge_reg;
    assign cut.from_corner  = lo_reg;
    assign cut.to_corner    = hi_reg;
    assign cut.cut_x        = x_reg;
    assign cut.cut_y        = y_reg;
    assign cut.cut_z        = z_reg;
    assign cut.last_of_cube = last_reg;

endmodule

>>> hw/rtl/cube_edge_intersection.sv
// a cube with no cut edge passes front, queue and back, giving one no-cut result
// each cut edge passes back end states SEL, DIV (bit-serial), MUL, ADD and OUT
// the back end takes the next cube only once its last result has been taken
// the front and a two-deep queue take new cubes while the back end works
// reset: rst_n is asynchronous active low and empties front, queue and back end
// ----------------------------------------------------------------------------
// cube_edge_intersection
// marching cubes edge cut finder: cube index and interpolated cut points
// ----------------------------------------------------------------------------
module cube_edge_intersection
    import cef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cef_cube_if.sink   cube,
    cef_cut_if.source  cut
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    cef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cube       (cube),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    cef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    cef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .cut       (cut)
    );

    a_nocut_last: assert property (@(posedge clk) disable iff (!rst_n)
        cut.valid && !cut.has_cut |-> cut.last_of_cube && cut.edge_number == 4'd0)
        else $error("no-cut result must close the cube");

    a_cut_order: assert property (@(posedge clk) disable iff (!rst_n)
        cut.valid && cut.has_cut |-> cut.from_corner < cut.to_corner
            && cut.edge_number < 4'd12)
        else $error("bad edge on cut result");

    a_cut_sign: assert property (@(posedge clk) disable iff (!rst_n)
        cut.valid && cut.has_cut |->
            cut.cube_index[cut.from_corner] != cut.cube_index[cut.to_corner])
        else $error("cut edge corners share a sign");

endmodule
